[rtl/bbs_pkg.sv]
// Package for the bracketing bisection step block: widths, outcome and
// register codes, configuration and queue entry types.
// No dependencies.
`default_nettype none

package bbs_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int COUNT_BITS = 16;
    localparam int TOL_BITS   = WORD_BITS - 1;
    localparam int IDX_BITS   = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [WORD_BITS-1:0] ONE_Q = WORD_BITS'(64'd1 << FRAC_BITS);
    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    localparam logic [TOL_BITS-1:0]  TOLERANCE_RESET = TOL_BITS'(655);
    localparam logic [TOL_BITS-1:0]  GROWTH_RESET    = TOL_BITS'(131072);

    typedef enum logic [2:0] {
        OUT_UNSOLVED     = 3'd0,
        OUT_SOLVED       = 3'd1,
        OUT_EMPTY        = 3'd2,
        OUT_LOW_REACHED  = 3'd3,
        OUT_HIGH_REACHED = 3'd4
    } outcome_t;

    typedef enum logic [2:0] {
        REG_TOLERANCE       = 3'd0,
        REG_MINIMUM         = 3'd1,
        REG_MINIMUM_DEFINED = 3'd2,
        REG_MAXIMUM         = 3'd3,
        REG_MAXIMUM_DEFINED = 3'd4,
        REG_INITIAL_GUESS   = 3'd5,
        REG_INITIAL_DEFINED = 3'd6,
        REG_GROWTH_MULTIPLE = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        BK_IDLE,
        BK_FIN
    } back_state_t;

    typedef struct packed {
        logic [TOL_BITS-1:0]         tolerance;
        logic signed [WORD_BITS-1:0] minimum;
        logic                        minimum_defined;
        logic signed [WORD_BITS-1:0] maximum;
        logic                        maximum_defined;
        logic signed [WORD_BITS-1:0] initial_guess;
        logic                        initial_defined;
        logic [TOL_BITS-1:0]         growth_multiple;
    } cfg_t;

    // Classified error: within tolerance, or the sign of the error
    typedef struct packed {
        logic solved;
        logic negative;
    } cls_t;

endpackage

`default_nettype wire

[rtl/bbs_front.sv]
// Front end: accepts error transactions and classifies them against the tolerance.
// Depends on bbs_pkg.
`default_nettype none

module bbs_front import bbs_pkg::*;
(
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [WORD_BITS-1:0] status_offset,
    input  logic [TOL_BITS-1:0]         tolerance,
    input  logic                        q_full,
    output logic                        q_push,
    output cls_t                        q_data
);

    logic [WORD_BITS-1:0] err_mag;

    always_comb
    begin
        err_mag = status_offset[WORD_BITS-1] ? WORD_BITS'(-status_offset)
                                             : WORD_BITS'(status_offset);
        q_data.solved   = err_mag < {1'b0, tolerance};
        q_data.negative = status_offset[WORD_BITS-1];
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

endmodule

`default_nettype wire

[rtl/bbs_queue.sv]
// Two-entry queue of classified errors between front and back end.
// Depends on bbs_pkg.
`default_nettype none

module bbs_queue import bbs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cls_t push_data,
    input  logic pop,
    output cls_t pop_data,
    output logic full,
    output logic not_empty
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    cls_t                mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [PTR_BITS:0]   count_reg;
    logic [PTR_BITS:0]   count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign pop_data  = mem[rd_ptr_reg];
    assign full      = count_reg == (PTR_BITS+1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;

endmodule

`default_nettype wire

[rtl/bbs_back.sv]
// Back end: search state, BK_IDLE/BK_FIN update sequencer and result register.
// Depends on bbs_pkg.
`default_nettype none

module bbs_back import bbs_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  logic                         restart,
    input  logic                         q_not_empty,
    input  cls_t                         q_data,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [WORD_BITS-1:0]  next_trial,
    output logic [2:0]                   outcome,
    output logic                         finished,
    output logic [COUNT_BITS-1:0]        iteration_count
);

    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int WIDE_BITS = WORD_BITS + 2;
    localparam int HALF_BITS = WORD_BITS + 1;

    back_state_t state_reg;
    back_state_t state_next;

    cls_t                         cls_reg;
    logic [PROD_BITS-1:0]         prod_reg;
    logic signed [WORD_BITS-1:0]  trial_reg;
    logic signed [WORD_BITS-1:0]  trial_next;
    logic signed [WORD_BITS-1:0]  low_reg;
    logic signed [WORD_BITS-1:0]  low_next;
    logic                         low_known_reg;
    logic                         low_known_next;
    logic signed [WORD_BITS-1:0]  high_reg;
    logic signed [WORD_BITS-1:0]  high_next;
    logic                         high_known_reg;
    logic                         high_known_next;
    logic                         pending_reg;
    logic                         pending_next;
    logic [COUNT_BITS-1:0]        count_reg;
    logic [COUNT_BITS-1:0]        count_next;

    logic                         out_valid_reg;
    logic signed [WORD_BITS-1:0]  out_trial_reg;
    outcome_t                     out_outcome_reg;
    outcome_t                     outcome_next;
    logic [COUNT_BITS-1:0]        out_count_reg;

    logic                         commit;
    logic [WORD_BITS-1:0]         trial_mag;
    logic [WORD_BITS-1:0]         factor;

    // bisection and comparison operands
    logic signed [WORD_BITS-1:0]  min_eff;
    logic signed [WORD_BITS-1:0]  mid_lo;
    logic signed [WORD_BITS-1:0]  mid_hi;
    logic signed [HALF_BITS-1:0]  mid_diff;
    logic signed [HALF_BITS-1:0]  mid_half;
    logic signed [WORD_BITS-1:0]  mid_val;
    logic signed [WIDE_BITS-1:0]  tol_w;
    logic signed [WIDE_BITS-1:0]  span;
    logic signed [WIDE_BITS-1:0]  floor_v;
    logic [PROD_BITS-FRAC_BITS-1:0] grown_q;
    logic signed [WORD_BITS-1:0]  grown;
    logic signed [WORD_BITS-1:0]  zero_start;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_not_empty)
                begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        q_pop  = 1'b0;
        commit = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                q_pop = q_not_empty;
            end
            BK_FIN:
            begin
                commit = !out_valid_reg || out_ready;
            end
            default:
            begin
                q_pop  = 1'b0;
                commit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        trial_mag = trial_reg[WORD_BITS-1] ? WORD_BITS'(-trial_reg) : WORD_BITS'(trial_reg);
        factor    = WORD_BITS'(ONE_Q) + {1'b0, cfg.growth_multiple};
    end

    // saturate the registered growth product
    always_comb
    begin
        grown_q = prod_reg[PROD_BITS-1:FRAC_BITS];
        if (trial_reg[WORD_BITS-1])
        begin
            if (grown_q > (PROD_BITS-FRAC_BITS)'({1'b1, {(WORD_BITS-1){1'b0}}}))
            begin
                grown = WORD_MIN;
            end
            else
            begin
                grown = WORD_BITS'(-grown_q[WORD_BITS-1:0]);
            end
        end
        else
        begin
            if (grown_q > (PROD_BITS-FRAC_BITS)'(WORD_MAX))
            begin
                grown = WORD_MAX;
            end
            else
            begin
                grown = grown_q[WORD_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        min_eff    = cfg.minimum_defined ? cfg.minimum : '0;
        zero_start = (cfg.minimum_defined && cfg.minimum > ONE_Q) ? cfg.minimum : ONE_Q;
        tol_w      = WIDE_BITS'({1'b0, cfg.tolerance});
        floor_v    = WIDE_BITS'(min_eff) + tol_w;

        // a negative error bisects up from the low bound, a positive one from the trial
        if (cls_reg.negative)
        begin
            mid_lo = low_known_reg ? low_reg : min_eff;
            mid_hi = trial_reg;
        end
        else
        begin
            mid_lo = trial_reg;
            mid_hi = high_known_reg ? high_reg : cfg.maximum;
        end
        span     = WIDE_BITS'(mid_hi) - WIDE_BITS'(mid_lo);
        mid_diff = HALF_BITS'(mid_hi) - HALF_BITS'(mid_lo);
        // round the half toward zero
        mid_half = (mid_diff + $signed(HALF_BITS'(mid_diff[HALF_BITS-1]))) >>> 1;
        mid_val  = WORD_BITS'(HALF_BITS'(mid_lo) + mid_half);
    end

    // search update
    always_comb
    begin
        trial_next      = trial_reg;
        low_next        = low_reg;
        low_known_next  = low_known_reg;
        high_next       = high_reg;
        high_known_next = high_known_reg;
        pending_next    = pending_reg;
        outcome_next    = OUT_UNSOLVED;
        count_next      = (&count_reg) ? count_reg : count_reg + 1'b1;

        priority if (cls_reg.solved)
        begin
            outcome_next = OUT_SOLVED;
        end
        else if (cls_reg.negative)
        begin
            high_next       = trial_reg;
            high_known_next = 1'b1;
            low_next        = mid_lo;
            low_known_next  = 1'b1;
            priority if (span < tol_w)
            begin
                outcome_next = OUT_EMPTY;
            end
            else if (WIDE_BITS'(trial_reg) < floor_v)
            begin
                outcome_next = OUT_LOW_REACHED;
            end
            else
            begin
                trial_next = mid_val;
            end
        end
        else
        begin
            low_next       = trial_reg;
            low_known_next = 1'b1;
            if (!high_known_reg)
            begin
                priority if (pending_reg && trial_reg == cfg.initial_guess)
                begin
                    pending_next = 1'b0;
                end
                else if (cfg.maximum_defined)
                begin
                    high_next       = cfg.maximum;
                    high_known_next = 1'b1;
                    trial_next      = mid_val;
                end
                else if (trial_reg == '0)
                begin
                    trial_next = zero_start;
                end
                else
                begin
                    trial_next = grown;
                end
            end
            else
            begin
                // low bound equals the trial here, so the empty test covers upper reached
                priority if (span < tol_w)
                begin
                    outcome_next = OUT_EMPTY;
                end
                else
                begin
                    trial_next = mid_val;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cls_reg  <= q_data;
            prod_reg <= PROD_BITS'(trial_mag) * PROD_BITS'(factor);
        end
        if (commit)
        begin
            out_trial_reg   <= trial_next;
            out_outcome_reg <= outcome_next;
            out_count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            trial_reg      <= '0;
            low_reg        <= '0;
            low_known_reg  <= 1'b0;
            high_reg       <= '0;
            high_known_reg <= 1'b0;
            pending_reg    <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (restart)
            begin
                trial_reg      <= cfg.initial_defined ? cfg.initial_guess
                                : (cfg.minimum_defined ? cfg.minimum : '0);
                low_reg        <= '0;
                low_known_reg  <= 1'b0;
                high_reg       <= '0;
                high_known_reg <= 1'b0;
                pending_reg    <= cfg.initial_defined;
                count_reg      <= '0;
            end
            else if (commit)
            begin
                trial_reg      <= trial_next;
                low_reg        <= low_next;
                low_known_reg  <= low_known_next;
                high_reg       <= high_next;
                high_known_reg <= high_known_next;
                pending_reg    <= pending_next;
                count_reg      <= count_next;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign next_trial      = out_trial_reg;
    assign outcome         = out_outcome_reg;
    assign finished        = out_outcome_reg != OUT_UNSOLVED;
    assign iteration_count = out_count_reg;

endmodule

`default_nettype wire

[rtl/bracketing_bisection_step.sv]
// Bracketing bisection step: each error transaction updates a Q16.16 trial
// value and its bracket, and yields the next trial, an outcome code and a
// saturating step count. The front end accepts an error whenever its
// two-entry queue has room; the back end handles one error at a time: in
// BK_IDLE it pops the error and registers the 32x32 multiply of the trial
// magnitude by the growth factor, and in BK_FIN it does the compare and
// bisection update and commits once the result register is free. A
// configuration write restarts the search on the following cycle. Depends on
// bbs_pkg, bbs_front, bbs_queue and bbs_back.
`default_nettype none

module bracketing_bisection_step import bbs_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [IDX_BITS-1:0]          cfg_index,
    input  logic [WORD_BITS-1:0]         cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [WORD_BITS-1:0]  status_offset,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [WORD_BITS-1:0]  next_trial,
    output logic [2:0]                   outcome,
    output logic                         finished,
    output logic [COUNT_BITS-1:0]        iteration_count
);

    cfg_t cfg_reg;
    logic restart_reg;
    logic cfg_hit;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_not_empty;
    cls_t q_in;
    cls_t q_out;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index[IDX_BITS-1:3] == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tolerance       <= TOLERANCE_RESET;
            cfg_reg.minimum         <= '0;
            cfg_reg.minimum_defined <= 1'b0;
            cfg_reg.maximum         <= '0;
            cfg_reg.maximum_defined <= 1'b0;
            cfg_reg.initial_guess   <= '0;
            cfg_reg.initial_defined <= 1'b0;
            cfg_reg.growth_multiple <= GROWTH_RESET;
            restart_reg             <= 1'b0;
        end
        else
        begin
            restart_reg <= cfg_hit;
            if (cfg_hit)
            begin
                unique case (cfg_reg_t'(cfg_index[2:0]))
                    REG_TOLERANCE:       cfg_reg.tolerance       <= cfg_data[TOL_BITS-1:0];
                    REG_MINIMUM:         cfg_reg.minimum         <= cfg_data;
                    REG_MINIMUM_DEFINED: cfg_reg.minimum_defined <= cfg_data[0];
                    REG_MAXIMUM:         cfg_reg.maximum         <= cfg_data;
                    REG_MAXIMUM_DEFINED: cfg_reg.maximum_defined <= cfg_data[0];
                    REG_INITIAL_GUESS:   cfg_reg.initial_guess   <= cfg_data;
                    REG_INITIAL_DEFINED: cfg_reg.initial_defined <= cfg_data[0];
                    REG_GROWTH_MULTIPLE: cfg_reg.growth_multiple <= cfg_data[TOL_BITS-1:0];
                    default:             cfg_reg.tolerance       <= cfg_reg.tolerance;
                endcase
            end
        end
    end

    bbs_front u_front
    (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .status_offset (status_offset),
        .tolerance     (cfg_reg.tolerance),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    bbs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    bbs_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .restart         (restart_reg),
        .q_not_empty     (q_not_empty),
        .q_data          (q_out),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .next_trial      (next_trial),
        .outcome         (outcome),
        .finished        (finished),
        .iteration_count (iteration_count)
    );

`ifndef SYNTHESIS
    a_finished_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (finished == (outcome != OUT_UNSOLVED)))
        else $error("finished flag disagrees with outcome");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (iteration_count != '0))
        else $error("result carries a zero step count");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_not_empty)
        else $error("back end popped an empty queue");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (q_full && !q_pop) |=> !$rose(q_not_empty))
        else $error("queue occupancy inconsistent");
`endif

endmodule

`default_nettype wire

[tb/sv/bracketing_bisection_step_tb.sv]
// Self-checking testbench for bracketing_bisection_step: a scoreboard class
// predicts every step of the Q16.16 bracket search and checks each result.
// Depends on bbs_pkg and the bracketing_bisection_step RTL.
module bracketing_bisection_step_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bbs_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_PAUSE  = 6;
    localparam int PHASE_ITEMS  = 400;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] trial;
        outcome_t                    outc;
        logic                        fin;
        logic [COUNT_BITS-1:0]       count;
    } step_result_t;

    class bisect_scoreboard;
        cfg_t                        cfg;
        logic signed [WORD_BITS-1:0] trial;
        logic signed [WORD_BITS-1:0] low_b;
        logic signed [WORD_BITS-1:0] high_b;
        logic                        low_known;
        logic                        high_known;
        logic                        guess_pending;
        logic [COUNT_BITS-1:0]       steps;
        outcome_t                    last_outcome;
        step_result_t                expected_steps[$];
        int                          fail_count;
        int                          checked;

        function new();
            cfg.tolerance       = TOLERANCE_RESET;
            cfg.minimum         = '0;
            cfg.minimum_defined = 1'b0;
            cfg.maximum         = '0;
            cfg.maximum_defined = 1'b0;
            cfg.initial_guess   = '0;
            cfg.initial_defined = 1'b0;
            cfg.growth_multiple = GROWTH_RESET;
            fail_count = 0;
            checked = 0;
            last_outcome = OUT_UNSOLVED;
            restart();
        endfunction

        function void restart();
            if (cfg.initial_defined)
                trial = cfg.initial_guess;
            else if (cfg.minimum_defined)
                trial = cfg.minimum;
            else
                trial = '0;
            low_b = '0;
            high_b = '0;
            low_known = 1'b0;
            high_known = 1'b0;
            guess_pending = cfg.initial_defined;
            steps = '0;
        endfunction

        function void write_reg(logic [IDX_BITS-1:0] idx, logic [WORD_BITS-1:0] data);
            // unused indexes leave the search untouched
            if (idx > IDX_BITS'(REG_GROWTH_MULTIPLE))
                return;
            case (cfg_reg_t'(idx[2:0]))
                REG_TOLERANCE:       cfg.tolerance = data[TOL_BITS-1:0];
                REG_MINIMUM:         cfg.minimum = data;
                REG_MINIMUM_DEFINED: cfg.minimum_defined = data[0];
                REG_MAXIMUM:         cfg.maximum = data;
                REG_MAXIMUM_DEFINED: cfg.maximum_defined = data[0];
                REG_INITIAL_GUESS:   cfg.initial_guess = data;
                REG_INITIAL_DEFINED: cfg.initial_defined = data[0];
                default:             cfg.growth_multiple = data[TOL_BITS-1:0];
            endcase
            restart();
        endfunction

        function void note_error(logic signed [WORD_BITS-1:0] status);
            longint       err, tol, mag, t, lo, hi, base, one, m, factor, prod;
            outcome_t     o;
            step_result_t r;
            err  = status;
            tol  = longint'(cfg.tolerance);
            mag  = err < 0 ? -err : err;
            t    = trial;
            lo   = low_b;
            hi   = high_b;
            one  = longint'(ONE_Q);
            base = cfg.minimum_defined ? longint'(cfg.minimum) : 0;
            o    = OUT_UNSOLVED;
            if (mag < tol) begin
                o = OUT_SOLVED;
            end
            else if (err < 0) begin
                hi = t;
                high_known = 1'b1;
                if (!low_known) begin
                    lo = base;
                    low_known = 1'b1;
                end
                if (hi - lo < tol)
                    o = OUT_EMPTY;
                else if (t < base + tol)
                    o = OUT_LOW_REACHED;
                else
                    t = lo + (hi - lo) / 2;
            end
            else begin
                lo = t;
                low_known = 1'b1;
                if (!high_known) begin
                    if (guess_pending && t == longint'(cfg.initial_guess)) begin
                        guess_pending = 1'b0;
                    end
                    else if (cfg.maximum_defined) begin
                        hi = longint'(cfg.maximum);
                        high_known = 1'b1;
                        t = lo + (hi - lo) / 2;
                    end
                    else if (t == 0) begin
                        m = cfg.minimum_defined ? base : one;
                        t = m > one ? m : one;
                    end
                    else begin
                        // grow the magnitude, truncate, saturate to the word
                        factor = (longint'(1) << FRAC_BITS) + longint'(cfg.growth_multiple);
                        prod = ((t < 0 ? -t : t) * factor) >>> FRAC_BITS;
                        if (t < 0)
                            t = prod > -longint'(WORD_MIN) ? longint'(WORD_MIN) : -prod;
                        else
                            t = prod > longint'(WORD_MAX) ? longint'(WORD_MAX) : prod;
                    end
                end
                else begin
                    if (hi - lo < tol)
                        o = OUT_EMPTY;
                    else if (hi - t < tol)
                        o = OUT_HIGH_REACHED;
                    else
                        t = lo + (hi - lo) / 2;
                end
            end
            if (steps != '1)
                steps++;
            trial  = t[WORD_BITS-1:0];
            low_b  = lo[WORD_BITS-1:0];
            high_b = hi[WORD_BITS-1:0];
            last_outcome = o;
            r.trial = trial;
            r.outc  = o;
            r.fin   = (o != OUT_UNSOLVED);
            r.count = steps;
            expected_steps.push_back(r);
        endfunction

        function void check_step(logic signed [WORD_BITS-1:0] t, logic [2:0] o, logic f,
                                 logic [COUNT_BITS-1:0] c);
            step_result_t e;
            checked++;
            if (expected_steps.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result %0d with nothing pending: trial %h outcome %0d count %0d",
                             checked, t, o, c);
                return;
            end
            e = expected_steps.pop_front();
            if (t !== e.trial || o !== e.outc || f !== e.fin || c !== e.count) begin
                fail_count++;
                if (fail_count <= 10)
                    $display({"result %0d: expected trial %h outcome %0d finished %0b ",
                              "count %0d, got trial %h outcome %0d finished %0b count %0d"},
                             checked, e.trial, e.outc, e.fin, e.count, t, o, f, c);
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [IDX_BITS-1:0]         cfg_index;
    logic [WORD_BITS-1:0]        cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic signed [WORD_BITS-1:0] status_offset;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [WORD_BITS-1:0] next_trial;
    logic [2:0]                  outcome;
    logic                        finished;
    logic [COUNT_BITS-1:0]       iteration_count;

    bisect_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int holdoff_left;
    int searched_items;

    bracketing_bisection_step dut (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("bracketing_bisection_step_tb: errors");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off when requested
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (holdoff_left > 0) begin
                out_ready <= 1'b0;
                holdoff_left--;
            end
            else begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_error(status_offset);
            if (out_valid && out_ready)
                sb.check_step(next_trial, outcome, finished, iteration_count);
        end
    end

    function automatic logic [WORD_BITS-1:0] rand_q16();
        case ($urandom_range(5))
            0: return $urandom_range(0, 32 << FRAC_BITS) - (16 << FRAC_BITS);
            1: return $urandom_range(0, 2048 << FRAC_BITS) - (1024 << FRAC_BITS);
            2: return $urandom;
            3: return $urandom_range(0, 4 << FRAC_BITS);
            4: return $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
            default: return $urandom_range(0, 1) ? ONE_Q : '0;
        endcase
    endfunction

    function automatic logic [WORD_BITS-1:0] rand_magnitude();
        case ($urandom_range(6))
            0: return '0;
            1: return $urandom | WORD_MAX;
            2: return $urandom;
            3: return $urandom_range(0, 1024);
            default: return $urandom_range(0, 2 << FRAC_BITS);
        endcase
    endfunction

    // call after a falling edge; returns at the falling edge after the transaction
    task automatic send_error(input logic [WORD_BITS-1:0] err);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        status_offset <= err;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_index(input logic [IDX_BITS-1:0] idx,
                               input logic [WORD_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [WORD_BITS-1:0] data);
        write_index(IDX_BITS'(r), data);
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // hold the sender until every pending result is out, then let the back end settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.expected_steps.size() != 0)
            @(negedge clk);
        repeat (DRAIN_PAUSE) @(negedge clk);
    endtask

    // one search: random restart, then errors steered toward a random target
    task automatic run_search(input int pause_at, input int hold);
        longint              target;
        longint              d;
        int                  steps;
        int                  n;
        logic [WORD_BITS-1:0] e;
        steps  = $urandom_range(8, 48);
        target = longint'($signed(rand_q16()));
        wait_drained();
        write_reg(REG_TOLERANCE, rand_magnitude());
        if ($urandom_range(4) < 2) write_reg(REG_MINIMUM, rand_q16());
        if ($urandom_range(4) < 2) write_reg(REG_MINIMUM_DEFINED, $urandom);
        if ($urandom_range(4) < 2) write_reg(REG_MAXIMUM, rand_q16());
        if ($urandom_range(4) < 2) write_reg(REG_MAXIMUM_DEFINED, $urandom);
        if ($urandom_range(4) < 2) write_reg(REG_INITIAL_GUESS, rand_q16());
        if ($urandom_range(4) < 2) write_reg(REG_INITIAL_DEFINED, $urandom);
        if ($urandom_range(4) < 2) write_reg(REG_GROWTH_MULTIPLE, rand_magnitude());
        end_writes();
        holdoff_left = hold;
        for (n = 0; n < steps; n++) begin
            if (n == pause_at)
                wait_drained();
            if ($urandom_range(9) == 0) begin
                e = $urandom;
            end
            else begin
                d = (target - longint'(sb.trial)) >>> $urandom_range(3);
                if (d > longint'(WORD_MAX))
                    d = WORD_MAX;
                else if (d < longint'(WORD_MIN))
                    d = WORD_MIN;
                e = d[WORD_BITS-1:0];
            end
            send_error(e);
            searched_items++;
            if (sb.last_outcome != OUT_UNSOLVED && $urandom_range(3) == 0)
                break;
        end
    endtask

    initial begin
        int idle_by_phase[4];
        int stall_by_phase[4];
        int p;
        int first;
        idle_by_phase  = '{0, 50, 0, 19};
        stall_by_phase = '{0, 0, 50, 19};
        sb = new();
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        status_offset = '0;
        idle_pct = 0;
        stall_pct = 0;
        holdoff_left = 0;
        searched_items = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: tolerance edge, word extremes, first growth from zero
        send_error(32'sd0);
        send_error(32'sd655);
        send_error(WORD_MAX);
        send_error(WORD_MIN);
        send_error(-32'sd654);
        send_error(-32'sd655);
        send_error(ONE_Q);

        // pending initial guess at zero, then growth from zero up to the minimum
        wait_drained();
        write_reg(REG_MINIMUM, 32'h0002_8000);
        write_reg(REG_MINIMUM_DEFINED, 32'd1);
        write_reg(REG_INITIAL_GUESS, 32'd0);
        write_reg(REG_INITIAL_DEFINED, 32'd1);
        end_writes();
        send_error(ONE_Q);
        send_error(ONE_Q);
        send_error(ONE_Q);
        send_error(-ONE_Q);
        // unused indexes must not restart the search
        wait_drained();
        write_index(8'hFF, $urandom);
        write_index(IDX_BITS'(REG_GROWTH_MULTIPLE + 1), $urandom);
        end_writes();
        send_error(-ONE_Q);

        // saturating growth, both signs
        wait_drained();
        write_reg(REG_INITIAL_DEFINED, 32'd0);
        write_reg(REG_GROWTH_MULTIPLE, 32'h7FFF_FFFF);
        end_writes();
        send_error(ONE_Q);
        send_error(ONE_Q);
        wait_drained();
        write_reg(REG_MINIMUM, WORD_MIN);
        end_writes();
        send_error(WORD_MAX);

        // maximum bounds the bracket until it empties
        wait_drained();
        write_reg(REG_GROWTH_MULTIPLE, 32'd0);
        write_reg(REG_MINIMUM_DEFINED, 32'd0);
        write_reg(REG_MAXIMUM, ONE_Q);
        write_reg(REG_MAXIMUM_DEFINED, 32'd1);
        write_reg(REG_TOLERANCE, 32'h0000_4000);
        end_writes();
        send_error(ONE_Q);
        send_error(ONE_Q);
        send_error(ONE_Q);

        // low bound reached from a negative initial guess
        wait_drained();
        write_reg(REG_INITIAL_GUESS, 32'hFFFE_0000);
        write_reg(REG_INITIAL_DEFINED, 32'd1);
        write_reg(REG_MAXIMUM, 32'h0000_2000);
        end_writes();
        send_error(ONE_Q);
        send_error(ONE_Q);
        send_error(-ONE_Q);

        for (p = 0; p < 4; p++) begin
            idle_pct = idle_by_phase[p];
            stall_pct = stall_by_phase[p];
            searched_items = 0;
            first = 1;
            while (searched_items < PHASE_ITEMS) begin
                run_search((first != 0 && p == 1) ? 5 : -1,
                           (first != 0 && p == 0) ? 300 : 0);
                first = 0;
            end
        end

        wait_drained();
        if (sb.fail_count == 0)
            $display("bracketing_bisection_step_tb: clean");
        else
            $display("bracketing_bisection_step_tb: errors");
        $finish;
    end
endmodule

[filelist.f]
rtl/bbs_pkg.sv
rtl/bbs_front.sv
rtl/bbs_queue.sv
rtl/bbs_back.sv
rtl/bracketing_bisection_step.sv
tb/sv/bracketing_bisection_step_tb.sv
